// ===== hdl/deque_with_half_rotate_assert.svh =====
// Assertion macros shared by the deque block. Each macro expects the signals clk and
// rst_n in the scope where it is used.
`ifndef DEQUE_WITH_HALF_ROTATE_ASSERT_SVH
`define DEQUE_WITH_HALF_ROTATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQHR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dqhr_pkg.sv =====
`default_nettype none

package dqhr_pkg;

    // Queue depth. The count and middle index widths follow from it.
    localparam int DEPTH    = 1024;

    // Widths of the request and response fields.
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = $clog2(DEPTH + 1);
    localparam int MIDDLE_W = $clog2(DEPTH / 2 + 1);

    typedef logic [OPCODE_W-1:0]        opcode_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0]        status_t;

    // Operation codes.
    localparam opcode_t OP_PUSH_FRONT = 3'd0;
    localparam opcode_t OP_POP_FRONT  = 3'd1;
    localparam opcode_t OP_PUSH_BACK  = 3'd2;
    localparam opcode_t OP_POP_BACK   = 3'd3;
    localparam opcode_t OP_ROTATE     = 3'd4;

    // Status codes.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/dqhr_req_if.sv =====
`default_nettype none

// Request channel: one operation per beat.
interface dqhr_req_if;
    logic              valid;
    logic              ready;
    dqhr_pkg::opcode_t opcode;
    dqhr_pkg::value_t  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/dqhr_rsp_if.sv =====
`default_nettype none

// Response channel: one result per beat.
interface dqhr_rsp_if;
    logic                              valid;
    logic                              ready;
    dqhr_pkg::value_t                  popped;
    dqhr_pkg::status_t                 status;
    logic [dqhr_pkg::COUNT_W-1:0]      count;
    logic [dqhr_pkg::MIDDLE_W-1:0]     middle_index;

    modport source (output valid, output popped, output status, output count,
                    output middle_index, input ready);
    modport sink (input valid, input popped, input status, input count,
                  input middle_index, output ready);
endinterface

`default_nettype wire

// ===== hdl/deque_with_half_rotate.sv =====
// Channel  Direction  Beat contents
// -------  ---------  ------------------------------------------------
// req      in         opcode (3 bits), value (32 bits, signed)
// rsp      out        popped (32 bits, signed), status (2), count (11),
//                     middle_index (10)
//
// Pushes, failed pops and no-op requests finish in the cycle they are accepted.
// A successful pop passes through S_POP to wait for the registered RAM read data.
// A rotate of n >= 2 elements moves floor(n/2) of them from front to back: one
// RAM read and one RAM write per moved element, overlapped; the RAM has a single write port.
// Reset clears the count and the front pointer; the RAM contents are not cleared.
// A request is taken only from idle, with the response register empty or draining.
`default_nettype none
`include "deque_with_half_rotate_assert.svh"

module deque_with_half_rotate (
    input wire logic   clk,
    input wire logic   rst_n,
    dqhr_req_if.sink   req,
    dqhr_rsp_if.source rsp
);

    localparam int DEPTH  = dqhr_pkg::DEPTH;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_ROT  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SLOT_W-1:0]     rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0]     wr_slot_reg, wr_slot_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic                  wpend_reg, wpend_next;
    logic                  ovalid_reg, ovalid_next;
    dqhr_pkg::value_t      popped_reg, popped_next;
    dqhr_pkg::status_t     status_reg, status_next;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [31:0]           ram_wdata;
    logic                  ram_re;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [31:0]           ram_rdata;

    logic                  accepted;
    logic                  push_taken;
    logic                  is_full;
    logic                  is_empty;
    logic [SLOT_W-1:0]     slot_before_front;
    logic [SLOT_W-1:0]     slot_back;
    logic [SLOT_W-1:0]     slot_last;
    logic [SLOT_W-1:0]     slot_rotated;
    logic [CNT_W-1:0]      moves;

    // Adds an offset of at most DEPTH to a slot, wrapping around the circular store.
    // The sum stays below twice DEPTH, so one conditional subtract is enough.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(s) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

    dqhr_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A request is taken only from idle, and only when the response register
    // will be free at the next edge.
    assign req.ready = (state_reg == S_IDLE) && (!ovalid_reg || rsp.ready);
    assign accepted  = req.valid && req.ready;

    assign is_full  = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign moves    = cnt_reg >> 1;

    assign push_taken = accepted && !is_full &&
                        (req.opcode == dqhr_pkg::OP_PUSH_FRONT ||
                         req.opcode == dqhr_pkg::OP_PUSH_BACK);

    // Slot arithmetic on the current front pointer. Going back by one slot is the
    // same as going forward by DEPTH - 1.
    assign slot_before_front = slot_add(front_reg, CNT_W'(DEPTH - 1));
    assign slot_back         = slot_add(front_reg, cnt_reg);
    assign slot_last         = slot_add(front_reg, cnt_reg - CNT_W'(1));
    assign slot_rotated      = slot_add(front_reg, moves);

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        cnt_next     = cnt_reg;
        rd_slot_next = rd_slot_reg;
        wr_slot_next = wr_slot_reg;
        left_next    = left_reg;
        wpend_next   = wpend_reg;
        ovalid_next  = ovalid_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;

        ram_we    = 1'b0;
        ram_waddr = front_reg;
        ram_wdata = req.value;
        ram_re    = 1'b0;
        ram_raddr = front_reg;

        // The response beat leaves when the sink takes it.
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accepted)
                begin
                    status_next = dqhr_pkg::ST_OK;
                    popped_next = '0;
                    unique case (req.opcode)
                        dqhr_pkg::OP_PUSH_FRONT:
                        begin
                            ovalid_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = dqhr_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_before_front;
                                front_next = slot_before_front;
                                cnt_next   = cnt_reg + CNT_W'(1);
                            end
                        end
                        dqhr_pkg::OP_PUSH_BACK:
                        begin
                            ovalid_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = dqhr_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = slot_back;
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        dqhr_pkg::OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = dqhr_pkg::ST_EMPTY;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = front_reg;
                                front_next = slot_add(front_reg, CNT_W'(1));
                                cnt_next   = cnt_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        dqhr_pkg::OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = dqhr_pkg::ST_EMPTY;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = slot_last;
                                cnt_next   = cnt_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                        end
                        dqhr_pkg::OP_ROTATE:
                        begin
                            if (cnt_reg >= CNT_W'(2))
                            begin
                                // The copy loop walks its own pointers, so the
                                // front pointer can take its final value now.
                                rd_slot_next = front_reg;
                                wr_slot_next = slot_back;
                                left_next    = moves;
                                wpend_next   = 1'b0;
                                front_next   = slot_rotated;
                                state_next   = S_ROT;
                            end
                            else
                            begin
                                ovalid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            ovalid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                popped_next = ram_rdata;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            S_ROT:
            begin
                // Each cycle reads the next front entry and writes the entry read
                // in the cycle before to the back. Read and write slots differ by
                // count - 1 modulo DEPTH, which is never zero here.
                if (left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_slot_reg;
                    rd_slot_next = slot_add(rd_slot_reg, CNT_W'(1));
                    left_next    = left_reg - CNT_W'(1);
                    wpend_next   = 1'b1;
                end
                else
                begin
                    wpend_next = 1'b0;
                end
                if (wpend_reg)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = wr_slot_reg;
                    ram_wdata    = ram_rdata;
                    wr_slot_next = slot_add(wr_slot_reg, CNT_W'(1));
                end
                if ((left_reg == '0) && !wpend_reg)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            cnt_reg    <= '0;
            left_reg   <= '0;
            wpend_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            wpend_reg  <= wpend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_slot_next;
        wr_slot_reg <= wr_slot_next;
        popped_reg  <= popped_next;
        status_reg  <= status_next;
    end

    // The count is stable while a response waits, since no request is taken then.
    assign rsp.valid        = ovalid_reg;
    assign rsp.popped       = popped_reg;
    assign rsp.status       = status_reg;
    assign rsp.count        = dqhr_pkg::COUNT_W'(cnt_reg);
    assign rsp.middle_index = dqhr_pkg::MIDDLE_W'(cnt_reg >> 1);

    `DQHR_ASSERT_SAME(a_count_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH), "count exceeds depth")
    `DQHR_ASSERT_SAME(a_busy_no_rsp, state_reg != S_IDLE, !ovalid_reg, "response while busy")
    `DQHR_ASSERT_NEXT(a_push_count, push_taken, cnt_reg == $past(cnt_reg) + CNT_W'(1), "push lost")
    `DQHR_ASSERT_SAME(a_rot_count, state_reg == S_ROT, $stable(cnt_reg), "count moved in rotate")

endmodule

`default_nettype wire

// ===== hdl/dqhr_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered read data.
module dqhr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
